// ===== rtl/core/tts_pkg.sv =====
package tts_pkg;

    // Fixed widths of the counters and of the result fields.
    localparam int CNT_W  = 32;
    localparam int MS_W   = 16;
    localparam int OP_W   = 2;
    localparam int SLOT_W = 3;
    localparam int MASK_W = 8;

    // Default configuration of the timer block.
    localparam int DEF_PERIODIC_SLOTS  = 8;
    localparam int DEF_ONESHOT_SLOTS   = 8;
    localparam int DEF_TICKS_PER_MILLI = 1;

    // Most negative counter value; a decrement saturates here.
    localparam logic [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

    // Operation codes of one transfer.
    typedef enum logic [OP_W-1:0] {
        OP_TICK         = 2'd0,
        OP_ADD_PERIODIC = 2'd1,
        OP_ADD_ONESHOT  = 2'd2
    } op_t;

    // Command from the decode stage to a channel bank.
    typedef struct packed {
        logic tick;
        logic add;
    } bank_cmd_t;

    // Saturating decrement of a signed counter.
    function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] c);
        return (c == CNT_MIN) ? c : c - 1'b1;
    endfunction

    // True when a signed counter is at or below zero.
    function automatic logic at_or_below_zero(input logic [CNT_W-1:0] c);
        return (c == '0) || c[CNT_W-1];
    endfunction

endpackage

// ===== rtl/core/tick_task_scheduler.sv =====
// Pipeline: the input register takes the command and its time scaled to ticks;
// the result register then strobes done while all channels update in parallel.
// Throughput: one command per cycle; busy stays low and the receiver cannot stall.
// Reset clears every counter, reload value, slot and the result strobe at once.
module tick_task_scheduler #(
    parameter int PERIODIC_SLOTS  = tts_pkg::DEF_PERIODIC_SLOTS,
    parameter int ONESHOT_SLOTS   = tts_pkg::DEF_ONESHOT_SLOTS,
    parameter int TICKS_PER_MILLI = tts_pkg::DEF_TICKS_PER_MILLI
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tts_pkg::OP_W-1:0]      op,
    input  logic [tts_pkg::MS_W-1:0]      ms_value,
    output logic                          done,
    output logic                          accepted,
    output logic [tts_pkg::SLOT_W-1:0]    slot_index,
    output logic [tts_pkg::MASK_W-1:0]    periodic_fire,
    output logic [tts_pkg::MASK_W-1:0]    oneshot_fire
);
    import tts_pkg::*;

    localparam int P_IDX_W = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1;
    localparam int O_IDX_W = (ONESHOT_SLOTS > 1) ? $clog2(ONESHOT_SLOTS) : 1;
    localparam int PF_W    = (PERIODIC_SLOTS > MASK_W) ? PERIODIC_SLOTS : MASK_W;
    localparam int OF_W    = (ONESHOT_SLOTS > MASK_W) ? ONESHOT_SLOTS : MASK_W;

    logic                      in_valid_reg;
    logic [OP_W-1:0]           op_reg;
    logic [CNT_W-1:0]          ticks_reg;
    logic [CNT_W-1:0]          ticks_next;

    bank_cmd_t                 p_cmd;
    bank_cmd_t                 o_cmd;
    logic [PERIODIC_SLOTS-1:0] p_fire;
    logic [ONESHOT_SLOTS-1:0]  o_fire;
    logic                      p_ok;
    logic                      o_ok;
    logic [P_IDX_W-1:0]        p_slot;
    logic [O_IDX_W-1:0]        o_slot;
    logic [P_IDX_W+SLOT_W-1:0] p_slot_ext;
    logic [O_IDX_W+SLOT_W-1:0] o_slot_ext;
    logic [PF_W-1:0]           p_fire_ext;
    logic [OF_W-1:0]           o_fire_ext;

    logic                      done_reg;
    logic                      accepted_reg;
    logic                      accepted_next;
    logic [SLOT_W-1:0]         slot_reg;
    logic [SLOT_W-1:0]         slot_next;
    logic [MASK_W-1:0]         pfire_reg;
    logic [MASK_W-1:0]         ofire_reg;

    // Every cycle can take a transfer.
    assign busy = 1'b0;

    // Scale the time from milliseconds to ticks.
    assign ticks_next = CNT_W'(ms_value) * CNT_W'(TICKS_PER_MILLI);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg    <= op;
            ticks_reg <= ticks_next;
        end
    end

    // Decode the registered operation into bank commands.
    always_comb
    begin
        p_cmd = '0;
        o_cmd = '0;
        if (in_valid_reg)
        begin
            case (op_reg)
                OP_TICK:
                begin
                    p_cmd.tick = 1'b1;
                    o_cmd.tick = 1'b1;
                end
                OP_ADD_PERIODIC: p_cmd.add = 1'b1;
                OP_ADD_ONESHOT:  o_cmd.add = 1'b1;
                default: ;
            endcase
        end
    end

    tts_periodic_bank #(
        .SLOTS (PERIODIC_SLOTS),
        .IDX_W (P_IDX_W)
    ) u_periodic (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (p_cmd),
        .ticks    (ticks_reg),
        .fire     (p_fire),
        .add_ok   (p_ok),
        .add_slot (p_slot)
    );

    tts_oneshot_bank #(
        .SLOTS (ONESHOT_SLOTS),
        .IDX_W (O_IDX_W)
    ) u_oneshot (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (o_cmd),
        .ticks    (ticks_reg),
        .fire     (o_fire),
        .add_ok   (o_ok),
        .add_slot (o_slot)
    );

    // Fit slot numbers and fire masks to the result field widths.
    assign p_slot_ext = {{SLOT_W{1'b0}}, p_slot};
    assign o_slot_ext = {{SLOT_W{1'b0}}, o_slot};
    assign p_fire_ext = PF_W'(p_fire);
    assign o_fire_ext = OF_W'(o_fire);

    // Result of the registered operation.
    always_comb
    begin
        accepted_next = 1'b0;
        slot_next     = '0;
        case (op_reg)
            OP_TICK: accepted_next = 1'b1;
            OP_ADD_PERIODIC:
            begin
                accepted_next = p_ok;
                slot_next     = p_ok ? p_slot_ext[SLOT_W-1:0] : '0;
            end
            OP_ADD_ONESHOT:
            begin
                accepted_next = o_ok;
                slot_next     = o_ok ? o_slot_ext[SLOT_W-1:0] : '0;
            end
            default: ;
        endcase
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
        slot_reg     <= slot_next;
        pfire_reg    <= p_fire_ext[MASK_W-1:0];
        ofire_reg    <= o_fire_ext[MASK_W-1:0];
    end

    assign done          = done_reg;
    assign accepted      = accepted_reg;
    assign slot_index    = slot_reg;
    assign periodic_fire = pfire_reg;
    assign oneshot_fire  = ofire_reg;

    // A transfer always yields a result, strobed on done after the input and result registers.
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("command transfer produced no result");

    // A result never appears without an earlier command transfer behind it.
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a command transfer");

    // Fire bits only come with an accepted tick, which assigns no slot.
    a_fire_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (periodic_fire != '0 || oneshot_fire != '0) |-> (done && accepted && slot_index == '0))
        else $error("fire mask outside a tick result");

endmodule

// ===== rtl/core/tts_periodic_bank.sv =====
module tts_periodic_bank #(
    parameter int SLOTS = 8,
    parameter int IDX_W = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tts_pkg::bank_cmd_t           cmd,
    input  logic [tts_pkg::CNT_W-1:0]    ticks,
    output logic [SLOTS-1:0]             fire,
    output logic                         add_ok,
    output logic [IDX_W-1:0]             add_slot
);
    import tts_pkg::*;

    localparam int USED_W = $clog2(SLOTS + 1);

    logic [CNT_W-1:0]  reload_reg [SLOTS];
    logic [CNT_W-1:0]  reload_next [SLOTS];
    logic [CNT_W-1:0]  count_reg [SLOTS];
    logic [CNT_W-1:0]  count_next [SLOTS];
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] used_next;

    // Room remains while fewer channels than slots are registered.
    assign add_ok   = (used_reg < USED_W'(SLOTS));
    assign add_slot = used_reg[IDX_W-1:0];

    // Tick all registered channels in parallel, or append one channel.
    always_comb
    begin
        logic [CNT_W-1:0] dec;
        fire      = '0;
        used_next = used_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            reload_next[i] = reload_reg[i];
            count_next[i]  = count_reg[i];
            dec            = dec_sat(count_reg[i]);
            if (cmd.tick && (i < int'(used_reg)))
            begin
                if (at_or_below_zero(dec))
                begin
                    fire[i]       = 1'b1;
                    count_next[i] = dec + reload_reg[i];
                end
                else
                begin
                    count_next[i] = dec;
                end
            end
            else if (cmd.add && add_ok && (USED_W'(i) == used_reg))
            begin
                reload_next[i] = ticks;
                count_next[i]  = ticks;
            end
        end
        if (cmd.add && add_ok)
        begin
            used_next = used_reg + 1'b1;
        end
    end

    // Channel state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                reload_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end
        else
        begin
            used_reg <= used_next;
            for (int i = 0; i < SLOTS; i++)
            begin
                reload_reg[i] <= reload_next[i];
                count_reg[i]  <= count_next[i];
            end
        end
    end

endmodule

// ===== rtl/core/tts_oneshot_bank.sv =====
module tts_oneshot_bank #(
    parameter int SLOTS = 8,
    parameter int IDX_W = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tts_pkg::bank_cmd_t           cmd,
    input  logic [tts_pkg::CNT_W-1:0]    ticks,
    output logic [SLOTS-1:0]             fire,
    output logic                         add_ok,
    output logic [IDX_W-1:0]             add_slot
);
    import tts_pkg::*;

    logic [SLOTS-1:0] active_reg;
    logic [SLOTS-1:0] active_next;
    logic [CNT_W-1:0] count_reg [SLOTS];
    logic [CNT_W-1:0] count_next [SLOTS];

    // Lowest free slot: scan from the top so the lowest one wins.
    always_comb
    begin
        add_ok   = 1'b0;
        add_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                add_ok   = 1'b1;
                add_slot = IDX_W'(i);
            end
        end
    end

    // Count down every active slot, or take the lowest free one.
    always_comb
    begin
        logic [CNT_W-1:0] dec;
        fire = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            active_next[i] = active_reg[i];
            count_next[i]  = count_reg[i];
            dec            = dec_sat(count_reg[i]);
            if (cmd.tick && active_reg[i])
            begin
                if (at_or_below_zero(dec))
                begin
                    fire[i]        = 1'b1;
                    active_next[i] = 1'b0;
                    count_next[i]  = '0;
                end
                else
                begin
                    count_next[i] = dec;
                end
            end
            else if (cmd.add && add_ok && (IDX_W'(i) == add_slot))
            begin
                active_next[i] = 1'b1;
                count_next[i]  = ticks;
            end
        end
    end

    // Slot state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            active_reg <= active_next;
            for (int i = 0; i < SLOTS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

// ===== sim/tick_task_scheduler_tb.sv =====
`timescale 1ns / 1ps

module tick_task_scheduler_tb;

    import tts_pkg::*;

    localparam int PERIODIC_SLOTS  = DEF_PERIODIC_SLOTS;
    localparam int ONESHOT_SLOTS   = DEF_ONESHOT_SLOTS;
    localparam int TICKS_PER_MILLI = DEF_TICKS_PER_MILLI;

    // Op code with no operation behind it; the block must ignore it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_COMMANDS = 650;
    localparam int CYCLE_LIMIT     = 100000;
    localparam int DRAIN_CYCLES    = 8;

    // One result of the timer block as it appears on the output ports.
    typedef struct packed {
        logic                accepted;
        logic [SLOT_W-1:0]   slot_index;
        logic [MASK_W-1:0]   periodic_fire;
        logic [MASK_W-1:0]   oneshot_fire;
    } timer_result_t;

    // Timer wheel predictor together with the queue of results still to come.
    class timer_wheel_scoreboard;
        logic [CNT_W-1:0] period_reload [PERIODIC_SLOTS];
        logic [CNT_W-1:0] period_count [PERIODIC_SLOTS];
        int unsigned      periods_used;
        bit               shot_live [ONESHOT_SLOTS];
        logic [CNT_W-1:0] shot_count [ONESHOT_SLOTS];
        timer_result_t    pending_results [$];
        int unsigned      errors;

        function new();
            for (int i = 0; i < PERIODIC_SLOTS; i++)
            begin
                period_reload[i] = '0;
                period_count[i]  = '0;
            end
            for (int i = 0; i < ONESHOT_SLOTS; i++)
            begin
                shot_live[i]  = 1'b0;
                shot_count[i] = '0;
            end
            periods_used = 0;
            errors       = 0;
        endfunction

        // A count stops at the most negative value instead of wrapping.
        function logic [CNT_W-1:0] count_down(logic [CNT_W-1:0] c);
            return (c == CNT_MIN) ? c : c - 1'b1;
        endfunction

        function bit expired(logic [CNT_W-1:0] c);
            return (c == '0) || c[CNT_W-1];
        endfunction

        // Advance the model by one accepted command and queue its result.
        function void note_command(logic [OP_W-1:0] code, logic [MS_W-1:0] ms);
            timer_result_t    r;
            logic [CNT_W-1:0] ticks;
            r = '0;
            ticks = CNT_W'(ms) * CNT_W'(TICKS_PER_MILLI);
            case (code)
                OP_TICK:
                begin
                    for (int i = 0; i < PERIODIC_SLOTS; i++)
                    begin
                        if (i < periods_used)
                        begin
                            period_count[i] = count_down(period_count[i]);
                            if (expired(period_count[i]))
                            begin
                                if (i < MASK_W)
                                    r.periodic_fire[i] = 1'b1;
                                period_count[i] = period_count[i] + period_reload[i];
                            end
                        end
                    end
                    for (int i = 0; i < ONESHOT_SLOTS; i++)
                    begin
                        if (shot_live[i])
                        begin
                            shot_count[i] = count_down(shot_count[i]);
                            if (expired(shot_count[i]))
                            begin
                                if (i < MASK_W)
                                    r.oneshot_fire[i] = 1'b1;
                                shot_live[i]  = 1'b0;
                                shot_count[i] = '0;
                            end
                        end
                    end
                    r.accepted = 1'b1;
                end
                OP_ADD_PERIODIC:
                begin
                    if (periods_used < PERIODIC_SLOTS)
                    begin
                        period_reload[periods_used] = ticks;
                        period_count[periods_used]  = ticks;
                        r.slot_index = SLOT_W'(periods_used);
                        r.accepted   = 1'b1;
                        periods_used++;
                    end
                end
                OP_ADD_ONESHOT:
                begin
                    // The lowest free slot wins.
                    for (int i = 0; i < ONESHOT_SLOTS; i++)
                    begin
                        if (!r.accepted && !shot_live[i])
                        begin
                            shot_live[i]  = 1'b1;
                            shot_count[i] = ticks;
                            r.slot_index  = SLOT_W'(i);
                            r.accepted    = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            pending_results.push_back(r);
        endfunction

        // Compare one result transfer with the oldest expectation.
        function void check_result(timer_result_t got);
            timer_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no command outstanding: acc=%0b slot=%0d pf=%02h of=%02h",
                         $time, got.accepted, got.slot_index, got.periodic_fire,
                         got.oneshot_fire);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.accepted !== want.accepted)
            begin
                $display("%0t: accepted mismatch: expected %0b, actual %0b",
                         $time, want.accepted, got.accepted);
                errors++;
            end
            if (got.slot_index !== want.slot_index)
            begin
                $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                         $time, want.slot_index, got.slot_index);
                errors++;
            end
            if (got.periodic_fire !== want.periodic_fire)
            begin
                $display("%0t: periodic_fire mismatch: expected %02h, actual %02h",
                         $time, want.periodic_fire, got.periodic_fire);
                errors++;
            end
            if (got.oneshot_fire !== want.oneshot_fire)
            begin
                $display("%0t: oneshot_fire mismatch: expected %02h, actual %02h",
                         $time, want.oneshot_fire, got.oneshot_fire);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   op;
    logic [MS_W-1:0]   ms_value;
    logic              done;
    logic              accepted;
    logic [SLOT_W-1:0] slot_index;
    logic [MASK_W-1:0] periodic_fire;
    logic [MASK_W-1:0] oneshot_fire;

    timer_wheel_scoreboard timer_sb = new();
    int unsigned           cycle_count = 0;
    int unsigned           commands_sent = 0;

    tick_task_scheduler #(
        .PERIODIC_SLOTS  (PERIODIC_SLOTS),
        .ONESHOT_SLOTS   (ONESHOT_SLOTS),
        .TICKS_PER_MILLI (TICKS_PER_MILLI)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .ms_value      (ms_value),
        .done          (done),
        .accepted      (accepted),
        .slot_index    (slot_index),
        .periodic_fire (periodic_fire),
        .oneshot_fire  (oneshot_fire)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Every strobed result is taken at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            timer_sb.check_result({accepted, slot_index, periodic_fire, oneshot_fire});
    end

    // Present one command and hold it until the transfer happens.
    task automatic send_command(input logic [OP_W-1:0] code, input logic [MS_W-1:0] ms);
        start    <= 1'b1;
        op       <= code;
        ms_value <= ms;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        timer_sb.note_command(code, ms);
        if (code != OP_UNUSED)
            commands_sent++;
    endtask

    // Drop start for a while; the data ports carry junk meanwhile.
    task automatic pause_sender(input int unsigned cycles);
        start    <= 1'b0;
        op       <= OP_W'($urandom);
        ms_value <= MS_W'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // Pick a random command, mostly ticks and short one-shot delays.
    task automatic send_random_command();
        int unsigned      pick;
        logic [MS_W-1:0]  ms;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            send_command(OP_TICK, MS_W'($urandom));
        else if (pick < 75)
        begin
            // Long delays are rare so that slots do not clog up for good.
            if ($urandom_range(0, 63) == 0)
                ms = MS_W'($urandom);
            else
                ms = MS_W'($urandom_range(0, 24));
            send_command(OP_ADD_ONESHOT, ms);
        end
        else if (pick < 93)
            send_command(OP_ADD_PERIODIC, MS_W'($urandom));
        else
            send_command(OP_UNUSED, MS_W'($urandom));
    endtask

    initial
    begin
        bit          steady;
        int unsigned burst_len;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        op       <= OP_TICK;
        ms_value <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes of the delays, zero period, zero delay,
        // full banks, and the unused op code.
        send_command(OP_TICK, 16'h0000);
        send_command(OP_ADD_PERIODIC, 16'h0000);
        send_command(OP_ADD_PERIODIC, 16'h0001);
        send_command(OP_ADD_PERIODIC, 16'hFFFF);
        send_command(OP_ADD_ONESHOT, 16'h0000);
        send_command(OP_ADD_ONESHOT, 16'hFFFF);
        send_command(OP_ADD_ONESHOT, 16'h0001);
        send_command(OP_TICK, 16'hFFFF);
        send_command(OP_TICK, 16'h0000);
        send_command(OP_UNUSED, 16'hFFFF);
        for (int i = 0; i < 8; i++)
            send_command(OP_ADD_ONESHOT, MS_W'(i + 2));
        for (int i = 0; i < 6; i++)
            send_command(OP_ADD_PERIODIC, MS_W'(i + 2));
        send_command(OP_TICK, 16'h5555);

        // Random part: bursts with random gaps, now and then a gapless stretch.
        commands_sent = 0;
        steady        = 1'b0;
        while (commands_sent < RANDOM_COMMANDS)
        begin
            burst_len = $urandom_range(1, 12);
            repeat (burst_len) send_random_command();
            if ($urandom_range(0, 7) == 0)
                steady = !steady;
            if (!steady)
                pause_sender($urandom_range(1, 6));
        end

        // Drain the result pipeline.
        pause_sender(0);
        while (timer_sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (timer_sb.errors == 0 && timer_sb.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
